/* src/ldf_pkg.sv */
package ldf_pkg;

	localparam int LENGTH_BYTES = 4;
	localparam int BYTE_W       = 8;
	localparam int LEN_W        = LENGTH_BYTES * BYTE_W;
	localparam int MAX_W        = 17;
	localparam int LEFT_W       = 17;
	localparam int CMP_W        = (LEN_W > MAX_W) ? LEN_W : MAX_W;
	localparam int CNT_W        = (LENGTH_BYTES > 2) ? $clog2(LENGTH_BYTES) : 1;
	localparam int STATUS_W     = 2;

	localparam logic [MAX_W-1:0] MAX_FRAME_DEFAULT = MAX_W'(64 * 1024);
	localparam logic [CNT_W-1:0] HDR_LAST          = CNT_W'(LENGTH_BYTES - 1);

	typedef enum logic [1:0] {
		PH_HEADER  = 2'd0,
		PH_TYPE    = 2'd1,
		PH_PAYLOAD = 2'd2,
		PH_HALTED  = 2'd3
	} phase_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_PAYLOAD = 2'd0,
		ST_EMPTY   = 2'd1,
		ST_ERROR   = 2'd2
	} status_t;

	typedef struct packed {
		logic              valid;
		logic [BYTE_W-1:0] data;
	} item_t;

	typedef struct packed {
		status_t           status;
		logic [BYTE_W-1:0] frame_type;
		logic [BYTE_W-1:0] payload_byte;
		logic              frame_end;
	} result_t;

	typedef struct packed {
		logic halted;
	} mon_t;

endpackage

/* src/ldf_in_stage.sv */
module ldf_in_stage (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic [ldf_pkg::BYTE_W-1:0] in_byte,
	input  logic                       take,
	output ldf_pkg::item_t             item
);

	logic                       valid_s1;
	logic [ldf_pkg::BYTE_W-1:0] data_s1;

	// The stage refills in the same cycle its byte moves on to the decoder.
	assign in_ready = !valid_s1 || take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			data_s1 <= in_byte;
		end
	end

	assign item.valid = valid_s1;
	assign item.data  = data_s1;

endmodule

/* src/ldf_decode.sv */
module ldf_decode (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_we,
	input  logic [ldf_pkg::MAX_W-1:0] cfg_wdata,
	input  ldf_pkg::item_t            item,
	output logic                      take,
	output logic                      res_valid,
	input  logic                      res_ready,
	output ldf_pkg::result_t          res,
	output ldf_pkg::mon_t             mon
);

	ldf_pkg::phase_t            phase_q, phase_d;
	logic [ldf_pkg::CNT_W-1:0]  hdr_cnt_q, hdr_cnt_d;
	logic [ldf_pkg::LEN_W-1:0]  len_q, len_d;
	logic [ldf_pkg::LEFT_W-1:0] left_q, left_d;
	logic [ldf_pkg::BYTE_W-1:0] type_q, type_d;
	logic [ldf_pkg::MAX_W-1:0]  max_q;

	logic                       res_valid_q;
	ldf_pkg::result_t           res_s2, res_d;
	logic                       produce;
	logic [ldf_pkg::LEN_W-1:0]  acc_new;
	logic [ldf_pkg::CMP_W-1:0]  cmp_len;
	logic [ldf_pkg::CMP_W-1:0]  cmp_max;

	assign acc_new = {len_q[ldf_pkg::LEN_W-ldf_pkg::BYTE_W-1:0], item.data};
	assign cmp_len = ldf_pkg::CMP_W'(acc_new);
	assign cmp_max = ldf_pkg::CMP_W'(max_q);

	always_comb begin
		phase_d   = phase_q;
		hdr_cnt_d = hdr_cnt_q;
		len_d     = len_q;
		left_d    = left_q;
		type_d    = type_q;
		produce   = 1'b0;
		res_d     = '0;
		case (phase_q)
			ldf_pkg::PH_HEADER: begin
				len_d = acc_new;
				if (hdr_cnt_q == ldf_pkg::HDR_LAST) begin
					hdr_cnt_d = '0;
					if ((cmp_len != '0) && (cmp_len <= cmp_max)) begin
						left_d  = ldf_pkg::LEFT_W'(cmp_len - ldf_pkg::CMP_W'(1));
						phase_d = ldf_pkg::PH_TYPE;
					end else begin
						phase_d         = ldf_pkg::PH_HALTED;
						produce         = 1'b1;
						res_d.status    = ldf_pkg::ST_ERROR;
						res_d.frame_end = 1'b1;
					end
				end else begin
					hdr_cnt_d = hdr_cnt_q + ldf_pkg::CNT_W'(1);
				end
			end
			ldf_pkg::PH_TYPE: begin
				type_d = item.data;
				if (left_q == '0) begin
					phase_d          = ldf_pkg::PH_HEADER;
					len_d            = '0;
					produce          = 1'b1;
					res_d.status     = ldf_pkg::ST_EMPTY;
					res_d.frame_type = item.data;
					res_d.frame_end  = 1'b1;
				end else begin
					phase_d = ldf_pkg::PH_PAYLOAD;
				end
			end
			ldf_pkg::PH_PAYLOAD: begin
				produce            = 1'b1;
				res_d.status       = ldf_pkg::ST_PAYLOAD;
				res_d.frame_type   = type_q;
				res_d.payload_byte = item.data;
				if (left_q <= ldf_pkg::LEFT_W'(1)) begin
					res_d.frame_end = 1'b1;
					left_d          = '0;
					len_d           = '0;
					phase_d         = ldf_pkg::PH_HEADER;
				end else begin
					left_d = left_q - ldf_pkg::LEFT_W'(1);
				end
			end
			default: begin
				// Halted: bytes are swallowed until reset.
			end
		endcase
	end

	// A byte that yields no result never waits on the output side.
	assign take = item.valid && (!res_valid_q || res_ready || !produce);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= ldf_pkg::PH_HEADER;
			hdr_cnt_q <= '0;
			len_q     <= '0;
			left_q    <= '0;
			type_q    <= '0;
			max_q     <= ldf_pkg::MAX_FRAME_DEFAULT;
		end else begin
			if (take) begin
				phase_q   <= phase_d;
				hdr_cnt_q <= hdr_cnt_d;
				len_q     <= len_d;
				left_q    <= left_d;
				type_q    <= type_d;
			end
			if (cfg_we) begin
				max_q <= cfg_wdata;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (take && produce) begin
			res_valid_q <= 1'b1;
		end else if (res_ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take && produce) begin
			res_s2 <= res_d;
		end
	end

	assign res_valid  = res_valid_q;
	assign res        = res_s2;
	assign mon.halted = (phase_q == ldf_pkg::PH_HALTED);

endmodule

/* src/length_prefixed_deframer_top.sv */
// Channel   Direction  Handshake                Payload
// in        input      in_valid / in_ready      in_byte
// cfg       input      cfg_we (no stall)        cfg_wdata (max_frame_length)
// out       output     out_valid / out_ready    status, frame_type, payload_byte, frame_end
//
// One byte per cycle is accepted while the output is not stalled; each byte waits in
// the input register, and its result, if any, enters the output register as the
// decoder takes it. The decode step between the two registers is combinational.
// Reset clears the frame state and sets the maximum length to 65536.
// Only bytes that make a result wait on a stalled output; good header bytes flow on.
module length_prefixed_deframer_top (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic [ldf_pkg::BYTE_W-1:0] in_byte,
	input  logic                       cfg_we,
	input  logic [ldf_pkg::MAX_W-1:0]  cfg_wdata,
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic [ldf_pkg::STATUS_W-1:0] status,
	output logic [ldf_pkg::BYTE_W-1:0] frame_type,
	output logic [ldf_pkg::BYTE_W-1:0] payload_byte,
	output logic                       frame_end
);

	ldf_pkg::item_t   item;
	ldf_pkg::result_t res;
	ldf_pkg::mon_t    mon;
	logic             take;

	ldf_in_stage u_in_stage (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_byte  (in_byte),
		.take     (take),
		.item     (item)
	);

	ldf_decode u_decode (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.item      (item),
		.take      (take),
		.res_valid (out_valid),
		.res_ready (out_ready),
		.res       (res),
		.mon       (mon)
	);

	assign status       = ldf_pkg::STATUS_W'(res.status);
	assign frame_type   = res.frame_type;
	assign payload_byte = res.payload_byte;
	assign frame_end    = res.frame_end;

	// An error result always leaves the decoder halted.
	a_err_halts: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && status == ldf_pkg::STATUS_W'(ldf_pkg::ST_ERROR)) |-> mon.halted)
		else $error("error result without halt");

	// Once halted, the decoder stays halted until reset.
	a_halt_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		mon.halted |=> mon.halted)
		else $error("left halted state");

	// No new result is made after the halt.
	a_halt_silent: assert property (@(posedge clk) disable iff (!arst_n)
		(mon.halted && out_valid && out_ready) |=> !out_valid)
		else $error("result after halt");

	// An error result carries no type and closes the frame.
	a_err_fields: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && status == ldf_pkg::STATUS_W'(ldf_pkg::ST_ERROR))
		|-> (frame_end && frame_type == '0 && payload_byte == '0))
		else $error("malformed error result");

endmodule

/* dv/tb_top.sv */
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	localparam string PASS_MSG = "** length_prefixed_deframer_top: PASSED **";
	localparam string FAIL_MSG = "** length_prefixed_deframer_top: FAILED **";
	localparam time LIMIT_NS = 2_000_000;
	localparam int DRAIN_CYCLES = 6;
	localparam int LONG_HOLD_CYCLES = 150;
	localparam int LONG_HOLD_AFTER = 400;
	localparam int LONG_HOLD_BACKLOG = 20;

	logic                         clk = 1'b0;
	logic                         arst_n = 1'b0;
	logic                         in_valid = 1'b0;
	logic                         in_ready;
	logic [ldf_pkg::BYTE_W-1:0]   in_byte = '0;
	logic                         cfg_we = 1'b0;
	logic [ldf_pkg::MAX_W-1:0]    cfg_wdata = '0;
	logic                         out_valid;
	logic                         out_ready = 1'b0;
	logic [ldf_pkg::STATUS_W-1:0] status;
	logic [ldf_pkg::BYTE_W-1:0]   frame_type;
	logic [ldf_pkg::BYTE_W-1:0]   payload_byte;
	logic                         frame_end;

	length_prefixed_deframer_top dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.in_byte     (in_byte),
		.cfg_we      (cfg_we),
		.cfg_wdata   (cfg_wdata),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.status      (status),
		.frame_type  (frame_type),
		.payload_byte(payload_byte),
		.frame_end   (frame_end)
	);

	// Byte stream waiting to be sent, and decoded records still owed by the block.
	logic [ldf_pkg::BYTE_W-1:0] stream_q[$];
	ldf_pkg::result_t           records_due[$];

	// Decoder state kept alongside the block.
	ldf_pkg::phase_t            dec_phase = ldf_pkg::PH_HEADER;
	int                         hdr_taken = 0;
	logic [ldf_pkg::LEN_W-1:0]  len_field = '0;
	logic [ldf_pkg::LEFT_W-1:0] left_count = '0;
	logic [ldf_pkg::BYTE_W-1:0] cur_type = '0;
	logic [ldf_pkg::MAX_W-1:0]  max_len = ldf_pkg::MAX_FRAME_DEFAULT;

	int mismatches = 0;
	int bytes_taken = 0;
	int queued_total = 0;
	int idle_pct = 0;
	bit calm = 1'b0;
	int send_gap = 0;
	int stall_left = 0;
	int hold_left = 0;
	bit long_hold_done = 1'b0;

	initial begin
		forever #2 clk = ~clk;
	end

	initial begin
		#(LIMIT_NS);
		$display(FAIL_MSG);
		$finish;
	end

	task automatic report_mismatch(input string what);
		if (mismatches < 100)
			$display("%0t mismatch: %s", $realtime, what);
		mismatches++;
	endtask

	function automatic ldf_pkg::result_t make_record(input ldf_pkg::status_t st,
			input logic [ldf_pkg::BYTE_W-1:0] ty,
			input logic [ldf_pkg::BYTE_W-1:0] data, input logic last);
		ldf_pkg::result_t r;
		r.status = st;
		r.frame_type = ty;
		r.payload_byte = data;
		r.frame_end = last;
		return r;
	endfunction

	task automatic restart_header();
		dec_phase = ldf_pkg::PH_HEADER;
		hdr_taken = 0;
		len_field = '0;
	endtask

	// Advances the decoder by one accepted byte and records any output it owes.
	task automatic deframe_byte(input logic [ldf_pkg::BYTE_W-1:0] b);
		logic last;
		case (dec_phase)
			ldf_pkg::PH_HEADER: begin
				len_field = {len_field[ldf_pkg::LEN_W-ldf_pkg::BYTE_W-1:0], b};
				if (hdr_taken + 1 >= ldf_pkg::LENGTH_BYTES) begin
					hdr_taken = 0;
					if (len_field >= 1 && len_field <= ldf_pkg::LEN_W'(max_len)) begin
						left_count = ldf_pkg::LEFT_W'(len_field - 1);
						dec_phase = ldf_pkg::PH_TYPE;
					end else begin
						dec_phase = ldf_pkg::PH_HALTED;
						records_due = {records_due,
							make_record(ldf_pkg::ST_ERROR, '0, '0, 1'b1)};
					end
				end else begin
					hdr_taken++;
				end
			end
			ldf_pkg::PH_TYPE: begin
				cur_type = b;
				if (left_count == 0) begin
					restart_header();
					records_due = {records_due,
						make_record(ldf_pkg::ST_EMPTY, cur_type, '0, 1'b1)};
				end else begin
					dec_phase = ldf_pkg::PH_PAYLOAD;
				end
			end
			ldf_pkg::PH_PAYLOAD: begin
				last = (left_count <= 1);
				records_due = {records_due,
					make_record(ldf_pkg::ST_PAYLOAD, cur_type, b, last)};
				if (last) begin
					left_count = '0;
					restart_header();
				end else begin
					left_count = left_count - 1'b1;
				end
			end
			default: ;
		endcase
	endtask

	// A negative fill gives random payload bytes.
	task automatic queue_frame(input logic [ldf_pkg::LEN_W-1:0] len,
			input logic [ldf_pkg::BYTE_W-1:0] ty, input int fill);
		for (int i = ldf_pkg::LENGTH_BYTES - 1; i >= 0; i--)
			stream_q = {stream_q, len[i*ldf_pkg::BYTE_W +: ldf_pkg::BYTE_W]};
		stream_q = {stream_q, ty};
		for (int i = 1; i < len; i++)
			stream_q = {stream_q, (fill < 0) ? ldf_pkg::BYTE_W'($urandom)
				: ldf_pkg::BYTE_W'(fill)};
		queued_total += ldf_pkg::LENGTH_BYTES + int'(len);
	endtask

	// Waits until every request is taken and every record has come back.
	task automatic settle();
		@(negedge clk);
		while (stream_q.size() != 0 || in_valid || records_due.size() != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_max(input logic [ldf_pkg::MAX_W-1:0] v);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		max_len = v;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// Sender.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			in_byte <= '0;
			send_gap = 0;
		end else begin
			if (in_valid && in_ready) begin
				deframe_byte(in_byte);
				bytes_taken++;
			end
			if (!in_valid || in_ready) begin
				if (send_gap > 0) begin
					send_gap--;
					in_valid <= 1'b0;
				end else if (!calm && stream_q.size() != 0 && $urandom_range(99) < idle_pct) begin
					send_gap = $urandom_range(6, 0);
					in_valid <= 1'b0;
				end else if (stream_q.size() != 0) begin
					in_valid <= 1'b1;
					in_byte <= stream_q.pop_front();
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Receiver ready, with one long hold-off so the block backs up into its input.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
			stall_left = 0;
			hold_left = 0;
		end else begin
			if (hold_left > 0) begin
				hold_left--;
				out_ready <= 1'b0;
			end else if (!long_hold_done && bytes_taken >= LONG_HOLD_AFTER
					&& stream_q.size() > LONG_HOLD_BACKLOG) begin
				long_hold_done = 1'b1;
				hold_left = LONG_HOLD_CYCLES - 1;
				out_ready <= 1'b0;
			end else if (stall_left > 0) begin
				stall_left--;
				out_ready <= 1'b0;
			end else if (!calm && $urandom_range(99) < idle_pct) begin
				stall_left = $urandom_range(6, 0);
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	// Result checker.
	always @(posedge clk) begin
		ldf_pkg::result_t exp_rec;
		if (arst_n && out_valid && out_ready) begin
			if (records_due.size() == 0) begin
				report_mismatch($sformatf("unexpected result status=%0d type=%02h data=%02h end=%0b",
					status, frame_type, payload_byte, frame_end));
			end else begin
				exp_rec = records_due.pop_front();
				if (status !== exp_rec.status)
					report_mismatch($sformatf("status %0d, expected %0d", status, exp_rec.status));
				if (frame_type !== exp_rec.frame_type)
					report_mismatch($sformatf("frame_type %02h, expected %02h",
						frame_type, exp_rec.frame_type));
				if (payload_byte !== exp_rec.payload_byte)
					report_mismatch($sformatf("payload_byte %02h, expected %02h",
						payload_byte, exp_rec.payload_byte));
				if (frame_end !== exp_rec.frame_end)
					report_mismatch($sformatf("frame_end %0b, expected %0b",
						frame_end, exp_rec.frame_end));
			end
		end
	end

	initial begin
		logic [ldf_pkg::MAX_W-1:0] cfg_val;
		logic [ldf_pkg::LEN_W-1:0] len;
		int cap;
		int pick;
		int phase_bytes;

		arst_n = 1'b0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed frames at the reset maximum: empty frame and extreme byte values.
		queue_frame(1, 8'h00, -1);
		queue_frame(2, 8'hFF, 8'h00);
		queue_frame(2, 8'hA5, 8'hFF);
		settle();
		// Smallest maximum, with a frame right at the limit.
		write_max(ldf_pkg::MAX_W'(1));
		queue_frame(1, 8'h3C, -1);

		while (queued_total < 950) begin
			settle();
			case ($urandom_range(4))
				0: cfg_val = ldf_pkg::MAX_W'(1);
				1: cfg_val = ldf_pkg::MAX_W'($urandom_range(48, 2));
				2: cfg_val = ldf_pkg::MAX_FRAME_DEFAULT;
				3: cfg_val = '1;
				default: cfg_val = ldf_pkg::MAX_W'($urandom_range(131071, 1));
			endcase
			write_max(cfg_val);
			case ($urandom_range(2))
				0: idle_pct = 0;
				1: idle_pct = 15;
				default: idle_pct = 40;
			endcase
			calm = (queued_total > 800);
			phase_bytes = 0;
			while (phase_bytes < 90) begin
				pick = $urandom_range(99);
				if (pick < 10)
					len = (max_len <= 48) ? ldf_pkg::LEN_W'(max_len) : 1;
				else begin
					cap = (pick < 70) ? 6 : 40;
					if (max_len < cap)
						cap = int'(max_len);
					len = $urandom_range(cap, 1);
				end
				queue_frame(len, ldf_pkg::BYTE_W'($urandom), -1);
				phase_bytes += ldf_pkg::LENGTH_BYTES + int'(len);
			end
		end

		// The block halts for good after a bad length, so that case closes the run.
		settle();
		calm = 1'b1;
		case ($urandom_range(2))
			0: begin
				write_max(ldf_pkg::MAX_W'($urandom_range(131071, 1)));
				queue_frame(0, 8'h00, -1);
			end
			1: begin
				write_max(ldf_pkg::MAX_W'($urandom_range(1000, 1)));
				len = $urandom_range(32'hFFFF_FFFF, max_len + 1);
				// Only the length field is sent; the bytes after it are swallowed anyway.
				for (int i = ldf_pkg::LENGTH_BYTES - 1; i >= 0; i--)
					stream_q = {stream_q, len[i*ldf_pkg::BYTE_W +: ldf_pkg::BYTE_W]};
			end
			default: begin
				write_max('0);
				len = $urandom_range(8, 1);
				queue_frame(len, 8'h00, -1);
			end
		endcase
		// Everything after the error is swallowed without a result.
		for (int i = 0; i < 20; i++)
			stream_q = {stream_q, ldf_pkg::BYTE_W'($urandom)};
		settle();

		if (mismatches == 0 && records_due.size() == 0)
			$display(PASS_MSG);
		else
			$display(FAIL_MSG);
		$finish;
	end

endmodule

/* files.f */
src/ldf_pkg.sv
src/ldf_in_stage.sv
src/ldf_decode.sv
src/length_prefixed_deframer_top.sv
dv/tb_top.sv
